### rtl/core/json_escape_utf8_sanitizer_defines.svh
// Assertion macros for the JSON escaper / UTF-8 sanitizer checkers.
// Depends on a clk and an rst signal in the scope where a macro is used.
`ifndef JSON_ESCAPE_UTF8_SANITIZER_DEFINES_SVH
`define JSON_ESCAPE_UTF8_SANITIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JESC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jesc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define JESC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jesc: next-cycle check failed");

`endif

### rtl/core/jesc_pkg.sv
// Package for the JSON escaper / UTF-8 sanitizer.
// Holds the run descriptor type, queue sizing and the byte constants.
`default_nettype none

package jesc_pkg;

  // Descriptor queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Most explicit bytes one item can carry ("\u00xx")
  localparam int MID_MAX = 6;

  // Output byte constants
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] RPL_B0    = 8'hEF;
  localparam logic [7:0] RPL_B1    = 8'hBF;
  localparam logic [7:0] RPL_B2    = 8'hBD;

  // Control characters with a short escape
  localparam logic [7:0] C_BS = 8'h08;
  localparam logic [7:0] C_HT = 8'h09;
  localparam logic [7:0] C_LF = 8'h0A;
  localparam logic [7:0] C_FF = 8'h0C;
  localparam logic [7:0] C_CR = 8'h0D;

  // One item's output: replacement chars first, then explicit bytes
  typedef struct packed {
    logic [2:0]                 fffd_cnt;
    logic [2:0]                 mid_len;
    logic [MID_MAX-1:0][7:0]    mid;
    logic                       str_end;
  } jesc_desc_t;

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = 8'h30 + {4'd0, v};
    end else begin
      d = 8'h57 + {4'd0, v};
    end
    return d;
  endfunction

  // Byte of the U+FFFD encoding at a given phase
  function automatic logic [7:0] fffd_byte(input logic [1:0] ph);
    logic [7:0] d;
    case (ph)
      2'd0:    d = RPL_B0;
      2'd1:    d = RPL_B1;
      default: d = RPL_B2;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/core/jesc_front.sv
// Front end: classifies each input byte, tracks the open UTF-8 sequence
// and builds one run descriptor. Depends on jesc_pkg.
`default_nettype none

module jesc_front
  import jesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       string_end,
  output logic            desc_push,
  output jesc_desc_t      desc
);

  logic [2:0][7:0] hb;
  logic [2:0][7:0] hb_next;
  logic [1:0]      cnt;
  logic [1:0]      cnt_next;
  logic [2:0]      seqlen;
  logic [2:0]      seqlen_next;

  logic       is_cont;
  logic       fresh;
  logic       bad;
  logic [1:0] pre;
  logic [1:0] post;
  logic [7:0] letter;

  // Classify the byte and build the descriptor
  always_comb begin
    desc        = '0;
    hb_next     = hb;
    cnt_next    = cnt;
    seqlen_next = seqlen;
    fresh       = 1'b0;
    bad         = 1'b0;
    pre         = 2'd0;
    post        = 2'd0;
    letter      = 8'h00;
    is_cont     = (in_byte[7:6] == 2'b10);

    if (cnt != 2'd0 && is_cont) begin
      if ({1'b0, cnt} + 3'd1 >= seqlen) begin
        // sequence complete: release held bytes and this one
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < cnt) desc.mid[i] = hb[i];
        end
        for (int i = 0; i < 4; i++) begin
          if (3'(i) == {1'b0, cnt}) desc.mid[i] = in_byte;
        end
        desc.mid_len = {1'b0, cnt} + 3'd1;
        cnt_next     = 2'd0;
        seqlen_next  = 3'd0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) == cnt) hb_next[i] = in_byte;
        end
        cnt_next = cnt + 2'd1;
      end
    end else begin
      // no open sequence, or a broken one: one replacement per held byte
      pre         = cnt;
      cnt_next    = 2'd0;
      seqlen_next = 3'd0;
      fresh       = 1'b1;
    end

    if (fresh) begin
      if (in_byte < 8'h20) begin
        unique case (in_byte)
          C_LF:    letter = CH_N;
          C_CR:    letter = CH_R;
          C_FF:    letter = CH_F;
          C_HT:    letter = CH_T;
          C_BS:    letter = CH_B;
          default: letter = 8'h00;
        endcase
        desc.mid[0] = CH_BSLASH;
        if (letter != 8'h00) begin
          desc.mid[1]  = letter;
          desc.mid_len = 3'd2;
        end else begin
          desc.mid[1]  = CH_U;
          desc.mid[2]  = CH_ZERO;
          desc.mid[3]  = CH_ZERO;
          desc.mid[4]  = hex_digit(in_byte[7:4]);
          desc.mid[5]  = hex_digit(in_byte[3:0]);
          desc.mid_len = 3'd6;
        end
      end else if (in_byte == CH_BSLASH || in_byte == CH_QUOTE) begin
        desc.mid[0]  = CH_BSLASH;
        desc.mid[1]  = in_byte;
        desc.mid_len = 3'd2;
      end else if (in_byte < 8'h80) begin
        desc.mid[0]  = in_byte;
        desc.mid_len = 3'd1;
      end else if (in_byte[7:5] == 3'b110) begin
        hb_next[0]  = in_byte;
        cnt_next    = 2'd1;
        seqlen_next = 3'd2;
      end else if (in_byte[7:4] == 4'b1110) begin
        hb_next[0]  = in_byte;
        cnt_next    = 2'd1;
        seqlen_next = 3'd3;
      end else if (in_byte[7:3] == 5'b11110) begin
        hb_next[0]  = in_byte;
        cnt_next    = 2'd1;
        seqlen_next = 3'd4;
      end else begin
        bad = 1'b1;
      end
    end

    // string cut short: one replacement per byte still held
    if (string_end && cnt_next != 2'd0) begin
      post        = cnt_next;
      cnt_next    = 2'd0;
      seqlen_next = 3'd0;
    end

    desc.fffd_cnt = {1'b0, pre} + {1'b0, post} + {2'd0, bad};
    desc.str_end  = string_end;
    desc_push     = accept && (desc.fffd_cnt != 3'd0 || desc.mid_len != 3'd0);
  end

  // Advance sequence state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      seqlen <= 3'd0;
    end else if (accept) begin
      cnt    <= cnt_next;
      seqlen <= seqlen_next;
    end
  end

  // Held bytes carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      hb <= hb_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jesc_queue.sv
// Short descriptor queue that decouples front and back.
// Depends on jesc_pkg for the descriptor type and depth.
`default_nettype none

module jesc_queue
  import jesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  jesc_desc_t      wr_desc,
  input  wire logic       rd_en,
  output jesc_desc_t      rd_desc,
  output logic            q_full,
  output logic            q_empty
);

  jesc_desc_t   slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign q_full  = (count == (QAW+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_desc = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + QAW'(1);
      if (rd_en) rd_ptr <= rd_ptr + QAW'(1);
      if (wr_en && !rd_en) begin
        count <= count + (QAW+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

  // Store descriptors
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_desc;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jesc_back.sv
// Back end: expands the head descriptor into output beats, one per cycle while
// the result is free or popped, through a result register. Depends on jesc_pkg.
`default_nettype none

module jesc_back
  import jesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  jesc_desc_t      head,
  output logic            q_pop,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            string_done
);

  logic       out_valid;
  logic [1:0] ph;
  logic [1:0] ph_next;
  logic [2:0] fdone;
  logic [2:0] fdone_next;
  logic [2:0] midx;
  logic [2:0] midx_next;

  logic       advance;
  logic       in_fffd;
  logic       last;
  logic [7:0] byte_cur;

  assign empty   = !out_valid;
  assign advance = !q_empty && (!out_valid || pop);

  // Pick the current byte of the run
  always_comb begin
    in_fffd    = (fdone != head.fffd_cnt);
    ph_next    = ph;
    fdone_next = fdone;
    midx_next  = midx;
    if (in_fffd) begin
      byte_cur = fffd_byte(ph);
      last     = (ph == 2'd2) && (fdone + 3'd1 == head.fffd_cnt) && (head.mid_len == 3'd0);
      if (ph == 2'd2) begin
        ph_next    = 2'd0;
        fdone_next = fdone + 3'd1;
      end else begin
        ph_next = ph + 2'd1;
      end
    end else begin
      byte_cur  = head.mid[midx];
      last      = (midx + 3'd1 == head.mid_len);
      midx_next = midx + 3'd1;
    end
    if (last) begin
      ph_next    = 2'd0;
      fdone_next = 3'd0;
      midx_next  = 3'd0;
    end
    q_pop = advance && last;
  end

  // Walk the run and hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ph        <= 2'd0;
      fdone     <= 3'd0;
      midx      <= 3'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      ph        <= ph_next;
      fdone     <= fdone_next;
      midx      <= midx_next;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= byte_cur;
      run_last    <= last;
      string_done <= last && head.str_end;
    end
  end

endmodule

`default_nettype wire

### rtl/core/json_escape_utf8_sanitizer.sv
// Top level of the JSON string escaper with UTF-8 sanitizing.
// Depends on jesc_pkg, jesc_front, jesc_queue and jesc_back.
//
//   channel   handshake          beat payload
//   -------   ----------------   ---------------------------------
//   input     push / full        in_byte, string_end
//   result    pop / empty        out_byte, run_last, string_done
//
// An input byte is taken every cycle while the 4-entry run queue has room.
// The back end sends one result beat per cycle while the result is popped, so
// throughput is bounded by the output bytes that each item produces.
// The first result of a byte passes through the run queue, then the result register.
// rst is synchronous and clears sequence state, queue occupancy and result valid.
// A stalled pop holds the result; full rises once the queue fills behind it.
`default_nettype none

module json_escape_utf8_sanitizer
  import jesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       string_end,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            string_done
);

  logic       accept;
  logic       desc_push;
  jesc_desc_t desc;
  jesc_desc_t head;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  jesc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .string_end (string_end),
    .desc_push  (desc_push),
    .desc       (desc)
  );

  jesc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (desc_push),
    .wr_desc (desc),
    .rd_en   (q_pop),
    .rd_desc (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  jesc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_done (string_done)
  );

endmodule

`default_nettype wire

### rtl/core/jesc_checker.sv
// Port-level checker for json_escape_utf8_sanitizer, bound to the top level.
// Depends on json_escape_utf8_sanitizer_defines.svh for the assertion macros.
`default_nettype none
`include "json_escape_utf8_sanitizer_defines.svh"

module jesc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic [7:0] out_byte,
  input wire logic       run_last,
  input wire logic       string_done
);

  // End of string only ever closes a run
  `JESC_ASSERT_IMP(a_done_is_last, !empty && string_done, run_last)

  // Control bytes never leave unescaped
  `JESC_ASSERT_IMP(a_no_ctrl_out, !empty, out_byte >= 8'h20)

  // A waiting beat holds until popped
  `JESC_ASSERT_NXT(a_hold_beat, !empty && !pop,
                   !empty && $stable(out_byte) && $stable(run_last) && $stable(string_done))

endmodule

bind json_escape_utf8_sanitizer jesc_checker u_jesc_checker (.*);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the JSON string escaper with UTF-8 sanitizing.
// Needs jesc_pkg and json_escape_utf8_sanitizer; predicts every output beat.
module tb_top;
  import jesc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 450;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 11;
  localparam logic [15:0][7:0] HEX_LUT = "fedcba9876543210";

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } raw_beat_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       run_end;
    logic       str_done;
  } esc_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       string_end = 1'b0;
  logic       pop = 1'b0;
  wire        full;
  wire        empty;
  wire  [7:0] out_byte;
  wire        run_last;
  wire        string_done;

  raw_beat_t raw_q[$];
  esc_beat_t escaped_q[$];
  logic [7:0] run_bytes[$];
  esc_beat_t want;

  // Predictor state: partial UTF-8 sequence
  logic [7:0] held[3];
  logic [1:0] held_n = 2'd0;
  logic [2:0] seq_len = 3'd0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_strings = 0;
  int errors = 0;
  int cycle_cnt = 0;
  wire calm = (n_accepted >= 150) && (n_accepted < 250);

  json_escape_utf8_sanitizer dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .string_end (string_end),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_done(string_done)
  );

  always #5 clk = ~clk;

  // One U+FFFD for every held byte, then drop the sequence
  function void flush_replacements();
    for (int i = 0; i < int'(held_n); i++) begin
      run_bytes.push_back(RPL_B0);
      run_bytes.push_back(RPL_B1);
      run_bytes.push_back(RPL_B2);
    end
    held_n  = 2'd0;
    seq_len = 3'd0;
  endfunction

  // Handle a byte with nothing held
  function void escape_fresh(input logic [7:0] b);
    logic [7:0] letter;
    letter = 8'h00;
    if (b < 8'h20) begin
      case (b)
        C_LF:    letter = CH_N;
        C_CR:    letter = CH_R;
        C_FF:    letter = CH_F;
        C_HT:    letter = CH_T;
        C_BS:    letter = CH_B;
        default: letter = 8'h00;
      endcase
      run_bytes.push_back(CH_BSLASH);
      if (letter != 8'h00) begin
        run_bytes.push_back(letter);
      end else begin
        run_bytes.push_back(CH_U);
        run_bytes.push_back(CH_ZERO);
        run_bytes.push_back(CH_ZERO);
        run_bytes.push_back(HEX_LUT[b[7:4]]);
        run_bytes.push_back(HEX_LUT[b[3:0]]);
      end
      return;
    end
    if (b == CH_BSLASH || b == CH_QUOTE) begin
      run_bytes.push_back(CH_BSLASH);
      run_bytes.push_back(b);
      return;
    end
    if (!b[7]) begin
      run_bytes.push_back(b);
      return;
    end
    if (b[7:5] == 3'b110) begin
      seq_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      seq_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      seq_len = 3'd4;
    end else begin
      run_bytes.push_back(RPL_B0);
      run_bytes.push_back(RPL_B1);
      run_bytes.push_back(RPL_B2);
      return;
    end
    held[0] = b;
    held_n  = 2'd1;
  endfunction

  // Work out the output run of one accepted input beat
  function void escape_and_sanitize(input logic [7:0] b, input logic fin);
    esc_beat_t e;
    if (held_n != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        if (int'(held_n) + 1 >= int'(seq_len)) begin
          for (int i = 0; i < int'(held_n); i++) run_bytes.push_back(held[i]);
          run_bytes.push_back(b);
          held_n  = 2'd0;
          seq_len = 3'd0;
        end else begin
          held[held_n] = b;
          held_n = held_n + 2'd1;
        end
      end else begin
        flush_replacements();
        escape_fresh(b);
      end
    end else begin
      escape_fresh(b);
    end
    if (fin && held_n != 2'd0) flush_replacements();
    foreach (run_bytes[i]) begin
      e.byte_val = run_bytes[i];
      e.run_end  = (i == run_bytes.size() - 1);
      e.str_done = e.run_end && fin;
      escaped_q.push_back(e);
    end
    run_bytes.delete();
  endfunction

  task automatic add_beat(input logic [7:0] b, input logic fin);
    raw_beat_t r;
    r.b   = b;
    r.fin = fin;
    raw_q.push_back(r);
    n_queued++;
  endtask

  // Random byte, ending the string about once in twelve
  task automatic put(input logic [7:0] b);
    add_beat(b, $urandom_range(0, 11) == 0);
  endtask

  task automatic put_cont();
    put({2'b10, 6'($urandom_range(0, 63))});
  endtask

  function automatic logic [7:0] random_lead(input int len);
    logic [7:0] lead;
    case (len)
      2:       lead = {3'b110, 5'($urandom_range(0, 31))};
      3:       lead = {4'b1110, 4'($urandom_range(0, 15))};
      default: lead = {5'b11110, 3'($urandom_range(0, 7))};
    endcase
    return lead;
  endfunction

  // Mostly well-formed text with random content, some noise and broken runs
  task automatic gen_unit();
    int kind;
    int len;
    int conts;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      put(8'($urandom_range(8'h20, 8'h7f)));
    end else if (kind < 35) begin
      put(8'($urandom_range(0, 31)));
    end else if (kind < 40) begin
      put($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
    end else if (kind < 80) begin
      len = (kind < 55) ? 2 : (kind < 68) ? 3 : 4;
      put(random_lead(len));
      for (int i = 1; i < len; i++) put_cont();
    end else if (kind < 88) begin
      len = $urandom_range(2, 4);
      conts = $urandom_range(0, len - 2);
      put(random_lead(len));
      for (int i = 0; i < conts; i++) put_cont();
      if ($urandom_range(0, 1)) put(8'($urandom_range(0, 8'h7f)));
      else put({2'b11, 6'($urandom_range(0, 63))});
    end else if (kind < 93) begin
      if ($urandom_range(0, 1)) put(8'($urandom_range(8'hf8, 8'hff)));
      else put_cont();
    end else begin
      put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_all_done();
    while (n_accepted != n_queued || escaped_q.size() != 0) @(posedge clk);
  endtask

  // Driver: one beat per handshake, random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        escape_and_sanitize(in_byte, string_end);
        n_accepted++;
        if (string_end) n_strings++;
      end
      if (!push || !full) begin
        if (raw_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          push       <= 1'b1;
          in_byte    <= raw_q[0].b;
          string_end <= raw_q[0].fin;
          void'(raw_q.pop_front());
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (escaped_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, actual out_byte=%h run_last=%b string_done=%b",
                   $time, out_byte, run_last, string_done);
        end else begin
          want = escaped_q.pop_front();
          n_checked++;
          if (out_byte !== want.byte_val) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.byte_val, out_byte);
          end
          if (run_last !== want.run_end) begin
            errors++;
            $display("%0t: run_last expected %b actual %b", $time, want.run_end, run_last);
          end
          if (string_done !== want.str_done) begin
            errors++;
            $display("%0t: string_done expected %b actual %b",
                     $time, want.str_done, string_done);
          end
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: escapes, extremes, each UTF-8 form and each repair case
    add_beat(C_LF, 1'b0);
    add_beat(C_CR, 1'b0);
    add_beat(C_FF, 1'b0);
    add_beat(C_HT, 1'b0);
    add_beat(C_BS, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h1f, 1'b0);
    add_beat(CH_BSLASH, 1'b0);
    add_beat(CH_QUOTE, 1'b0);
    add_beat(8'h7f, 1'b0);
    add_beat(8'hc3, 1'b0);
    add_beat(8'ha9, 1'b0);
    add_beat(8'he2, 1'b0);
    add_beat(8'h82, 1'b0);
    add_beat(8'hac, 1'b0);
    add_beat(8'hf4, 1'b0);
    add_beat(8'h8f, 1'b0);
    add_beat(8'hbf, 1'b0);
    add_beat(8'hbf, 1'b0);
    // lone continuation, then bad leads
    add_beat(8'h80, 1'b0);
    add_beat(8'hf8, 1'b0);
    add_beat(8'hff, 1'b0);
    // sequence broken by plain ASCII
    add_beat(8'he2, 1'b0);
    add_beat(8'h41, 1'b0);
    // sequence cut by the end of the string, then a one-byte string
    add_beat(8'hf0, 1'b0);
    add_beat(8'h90, 1'b1);
    add_beat(8'h20, 1'b1);
    wait_all_done();

    // Random traffic in two halves, holding off the sender between them
    while (n_queued < 27 + RANDOM_BEATS / 2) gen_unit();
    wait_all_done();
    while (n_queued < 27 + RANDOM_BEATS) gen_unit();
    add_beat(8'h2e, 1'b1);
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input bytes in %0d strings and %0d output bytes checked,",
             n_accepted, n_strings, n_checked);
    $display("including escapes, valid, broken and cut UTF-8 sequences and bad leads.");
    if (errors == 0 && escaped_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (escaped_q.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, escaped_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/jesc_pkg.sv
rtl/core/jesc_front.sv
rtl/core/jesc_queue.sv
rtl/core/jesc_back.sv
rtl/core/json_escape_utf8_sanitizer.sv
rtl/core/jesc_checker.sv
tb/tb_top.sv
